// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL. All checks sample on the rising edge of
// clock and are switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLOCKED(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   `ASSERT_CLOCKED(label, (ante) |=> (cons), msg)

`endif

// ===== src/ppidc_pkg.sv =====
package ppidc_pkg;

   // default parameter values
   localparam int SAMPLE_WIDTH   = 16;
   localparam int GAIN_FRAC_BITS = 16;

   // fixed field widths
   localparam int GAIN_WIDTH      = 32;
   localparam int LIMIT_WIDTH     = 16;
   localparam int DRIVE_WIDTH     = 40;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;

   // wide working width for the products and the sums built from them
   localparam int ACC_WIDTH      = 64;
   localparam int PROD_EXT_WIDTH = 72;
   localparam int PROD_CAP_LOG2  = 60;

   localparam logic signed [PROD_EXT_WIDTH-1:0] PROD_CAP =
      PROD_EXT_WIDTH'(1) << PROD_CAP_LOG2;

   localparam logic signed [ACC_WIDTH-1:0] DRIVE_MAX =
      (ACC_WIDTH'(1) << (DRIVE_WIDTH - 1)) - ACC_WIDTH'(1);
   localparam logic signed [ACC_WIDTH-1:0] DRIVE_MIN =
      -(ACC_WIDTH'(1) << (DRIVE_WIDTH - 1));

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_KP_GAIN,
      CSR_KI_GAIN,
      CSR_KD_GAIN,
      CSR_INTEGRAL_LIMIT
   } csr_index_type;

   typedef struct packed {
      logic signed [GAIN_WIDTH-1:0] kp;
      logic signed [GAIN_WIDTH-1:0] ki;
      logic signed [GAIN_WIDTH-1:0] kd;
      logic [LIMIT_WIDTH-1:0]       limit;
   } gains_type;

   // Saturate a sign-extended product to +/- 2^60.
   function automatic logic signed [ACC_WIDTH-1:0] sat_prod(
      input logic signed [PROD_EXT_WIDTH-1:0] p
   );
      logic signed [PROD_EXT_WIDTH-1:0] r;
      if (p > PROD_CAP) begin
         r = PROD_CAP;
      end else if (p < -PROD_CAP) begin
         r = -PROD_CAP;
      end else begin
         r = p;
      end
      return ACC_WIDTH'(r);
   endfunction

endpackage

// ===== src/ppidc_csr.sv =====
module ppidc_csr (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_write_enable,
   input  logic [ppidc_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [ppidc_pkg::CSR_DATA_WIDTH-1:0]      csr_write_data,
   output ppidc_pkg::gains_type                      gains,
   output logic                                      state_clear
);

   ppidc_pkg::gains_type gains_ff;
   ppidc_pkg::gains_type gains_in;

   always_comb begin
      gains_in = gains_ff;
      if (csr_write_enable) begin
         unique case (ppidc_pkg::csr_index_type'(csr_index))
            ppidc_pkg::CSR_KP_GAIN: begin
               gains_in.kp = csr_write_data;
            end
            ppidc_pkg::CSR_KI_GAIN: begin
               gains_in.ki = csr_write_data;
            end
            ppidc_pkg::CSR_KD_GAIN: begin
               gains_in.kd = csr_write_data;
            end
            ppidc_pkg::CSR_INTEGRAL_LIMIT: begin
               gains_in.limit = csr_write_data[ppidc_pkg::LIMIT_WIDTH-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff <= '0;
      end else begin
         gains_ff <= gains_in;
      end
   end

   // every index in the 2-bit space names a register, so each write clears
   assign gains       = gains_ff;
   assign state_clear = csr_write_enable;

endmodule

// ===== src/ppidc_err_stage.sv =====
module ppidc_err_stage #(
   parameter int SAMPLE_WIDTH = ppidc_pkg::SAMPLE_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_measured_value,
   input  logic signed [SAMPLE_WIDTH-1:0] req_target_value,
   input  logic                           advance,
   output logic                           err_valid,
   output logic signed [SAMPLE_WIDTH:0]   err_value
);

   logic                         valid_ff;
   logic                         valid_in;
   logic signed [SAMPLE_WIDTH:0] err_ff;
   logic signed [SAMPLE_WIDTH:0] err_in;
   logic                         accept;

   assign req_ready = !valid_ff || advance;
   assign accept    = req_valid && req_ready;

   // widen by one bit so the difference never wraps
   assign err_in = (SAMPLE_WIDTH + 1)'(req_target_value)
                 - (SAMPLE_WIDTH + 1)'(req_measured_value);

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         err_ff <= err_in;
      end
   end

   assign err_valid = valid_ff;
   assign err_value = err_ff;

endmodule

// ===== src/ppidc_calc.sv =====
module ppidc_calc #(
   parameter int SAMPLE_WIDTH   = ppidc_pkg::SAMPLE_WIDTH,
   parameter int GAIN_FRAC_BITS = ppidc_pkg::GAIN_FRAC_BITS
) (
   input  ppidc_pkg::gains_type                                          gains,
   input  logic signed [SAMPLE_WIDTH:0]                                  err_value,
   input  logic signed [SAMPLE_WIDTH:0]                                  prev_error,
   input  logic signed [ppidc_pkg::LIMIT_WIDTH+GAIN_FRAC_BITS:0]         integral,
   output logic signed [ppidc_pkg::LIMIT_WIDTH+GAIN_FRAC_BITS:0]         integral_next,
   output logic signed [ppidc_pkg::DRIVE_WIDTH-1:0]                      drive_value,
   output logic                                                          integral_clamped
);

   localparam int ERR_W  = SAMPLE_WIDTH + 1;
   localparam int DIFF_W = SAMPLE_WIDTH + 2;
   localparam int INT_W  = ppidc_pkg::LIMIT_WIDTH + GAIN_FRAC_BITS + 1;
   localparam int ACC_W  = ppidc_pkg::ACC_WIDTH;
   localparam int EXT_W  = ppidc_pkg::PROD_EXT_WIDTH;
   localparam int PE_W   = ppidc_pkg::GAIN_WIDTH + ERR_W;
   localparam int PD_W   = ppidc_pkg::GAIN_WIDTH + DIFF_W;

   logic signed [DIFF_W-1:0] diff;
   logic signed [PE_W-1:0]   kp_prod;
   logic signed [PE_W-1:0]   ki_prod;
   logic signed [PD_W-1:0]   kd_prod;
   logic signed [ACC_W-1:0]  kp_term;
   logic signed [ACC_W-1:0]  ki_term;
   logic signed [ACC_W-1:0]  kd_term;
   logic signed [ACC_W-1:0]  limit_pos;
   logic signed [ACC_W-1:0]  limit_neg;
   logic signed [ACC_W-1:0]  sum_raw;
   logic signed [ACC_W-1:0]  sum_clamped;
   logic signed [ACC_W-1:0]  drive_raw;

   assign diff = DIFF_W'(err_value) - DIFF_W'(prev_error);

   // three independent products, each capped at +/- 2^60
   assign kp_prod = PE_W'(gains.kp) * PE_W'(err_value);
   assign ki_prod = PE_W'(gains.ki) * PE_W'(err_value);
   assign kd_prod = PD_W'(gains.kd) * PD_W'(diff);

   assign kp_term = ppidc_pkg::sat_prod(EXT_W'(kp_prod));
   assign ki_term = ppidc_pkg::sat_prod(EXT_W'(ki_prod));
   assign kd_term = ppidc_pkg::sat_prod(EXT_W'(kd_prod));

   assign limit_pos = ACC_W'(gains.limit) << GAIN_FRAC_BITS;
   assign limit_neg = -limit_pos;
   assign sum_raw   = ACC_W'(integral) + ki_term;

   always_comb begin
      sum_clamped      = sum_raw;
      integral_clamped = 1'b0;
      if (sum_raw > limit_pos) begin
         sum_clamped      = limit_pos;
         integral_clamped = 1'b1;
      end else if (sum_raw < limit_neg) begin
         sum_clamped      = limit_neg;
         integral_clamped = 1'b1;
      end
   end

   assign integral_next = INT_W'(sum_clamped);
   assign drive_raw     = kp_term + sum_clamped + kd_term;

   always_comb begin
      if (drive_raw > ppidc_pkg::DRIVE_MAX) begin
         drive_value = ppidc_pkg::DRIVE_WIDTH'(ppidc_pkg::DRIVE_MAX);
      end else if (drive_raw < ppidc_pkg::DRIVE_MIN) begin
         drive_value = ppidc_pkg::DRIVE_WIDTH'(ppidc_pkg::DRIVE_MIN);
      end else begin
         drive_value = ppidc_pkg::DRIVE_WIDTH'(drive_raw);
      end
   end

endmodule

// ===== src/positional_pid_clamped_integral_top.sv =====
// Channel   Direction  Handshake            Beat contents
// req       in         req_valid/req_ready  measured_value, target_value (signed samples)
// rsp       out        rsp_valid/rsp_ready  drive_value (Q24.16), integral_clamped
// csr       in         csr_write_enable     csr_index, csr_write_data (no wait state)
//
// One beat per cycle sustained while rsp_ready is high; a request is taken into the
// error register and then moves into the result register, which offers its result.
// The error register feeds one pass of three multipliers, the integral clamp
// and the output saturation, which also updates the loop state.
// Synchronous active-high reset clears gains, loop state and both valid flags.
// A full result register that is not taken stalls the error register, and
// req_ready drops only when both are full and rsp_ready is low.
`include "assert_macros.svh"

module positional_pid_clamped_integral_top #(
   parameter int SAMPLE_WIDTH   = ppidc_pkg::SAMPLE_WIDTH,
   parameter int GAIN_FRAC_BITS = ppidc_pkg::GAIN_FRAC_BITS
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]              req_measured_value,
   input  logic signed [SAMPLE_WIDTH-1:0]              req_target_value,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [ppidc_pkg::DRIVE_WIDTH-1:0]    rsp_drive_value,
   output logic                                        rsp_integral_clamped,
   input  logic                                        csr_write_enable,
   input  logic [ppidc_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [ppidc_pkg::CSR_DATA_WIDTH-1:0]        csr_write_data
);

   localparam int INT_W = ppidc_pkg::LIMIT_WIDTH + GAIN_FRAC_BITS + 1;

   ppidc_pkg::gains_type gains;
   logic                 state_clear;

   logic                         err_valid;
   logic signed [SAMPLE_WIDTH:0] err_value;
   logic                         advance;

   // loop state: previous error and clamped integral
   logic signed [SAMPLE_WIDTH:0] prev_error_ff;
   logic signed [SAMPLE_WIDTH:0] prev_error_in;
   logic signed [INT_W-1:0]      integral_ff;
   logic signed [INT_W-1:0]      integral_in;
   logic signed [INT_W-1:0]      integral_next;

   // result register
   logic                                     rsp_valid_ff;
   logic                                     rsp_valid_in;
   logic signed [ppidc_pkg::DRIVE_WIDTH-1:0] drive_ff;
   logic signed [ppidc_pkg::DRIVE_WIDTH-1:0] drive_next;
   logic                                     clamped_ff;
   logic                                     clamped_next;

   logic signed [INT_W-1:0] limit_bound;

   ppidc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .gains            (gains),
      .state_clear      (state_clear)
   );

   ppidc_err_stage #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_err_stage (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_measured_value (req_measured_value),
      .req_target_value   (req_target_value),
      .advance            (advance),
      .err_valid          (err_valid),
      .err_value          (err_value)
   );

   ppidc_calc #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_calc (
      .gains            (gains),
      .err_value        (err_value),
      .prev_error       (prev_error_ff),
      .integral         (integral_ff),
      .integral_next    (integral_next),
      .drive_value      (drive_next),
      .integral_clamped (clamped_next)
   );

   // move the held error into the result register when that is free or draining
   assign advance = err_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // a register write wins over any state update and clears the loop
   always_comb begin
      prev_error_in = prev_error_ff;
      integral_in   = integral_ff;
      if (state_clear) begin
         prev_error_in = '0;
         integral_in   = '0;
      end else if (advance) begin
         prev_error_in = err_value;
         integral_in   = integral_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         prev_error_ff <= '0;
         integral_ff   <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         prev_error_ff <= prev_error_in;
         integral_ff   <= integral_in;
      end
   end

   // hold the result payload until the next beat replaces it
   always_ff @(posedge clock) begin
      if (advance) begin
         drive_ff   <= drive_next;
         clamped_ff <= clamped_next;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_drive_value      = drive_ff;
   assign rsp_integral_clamped = clamped_ff;

   assign limit_bound = INT_W'(gains.limit) << GAIN_FRAC_BITS;

   `ASSERT_CLOCKED(a_integral_in_bounds,
      (integral_ff <= limit_bound) && (integral_ff >= -limit_bound),
      "integral outside the clamp bound")
   `ASSERT_NEXT(a_write_clears_state, csr_write_enable,
      (integral_ff == '0) && (prev_error_ff == '0),
      "register write did not clear the loop state")
   `ASSERT_NEXT(a_advance_fills_result, advance, rsp_valid_ff,
      "advanced beat did not reach the result register")
   `ASSERT_CLOCKED(a_stall_only_when_full, !req_ready |-> (err_valid && rsp_valid_ff),
      "request stalled with a free stage")

endmodule
